@@ rtl/core/tpf_pkg.sv @@
// Shared constants, codes and types for the two-level priority FIFO.
`timescale 1ns / 1ps
`default_nettype none

package tpf_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int MODE_W    = 2;
	localparam int DATA_W    = 64;
	localparam int STATUS_W  = 2;
	localparam int LEVEL_W   = 5;

	// Mode: bit 1 set means pop, else bit 0 picks the queue to push.
	localparam int MODE_POP_BIT    = 1;
	localparam int MODE_URGENT_BIT = 0;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/tpf_if.sv @@
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface tpf_in_if;
	logic                       valid;
	logic                       ready;
	logic [tpf_pkg::MODE_W-1:0] mode;
	logic [tpf_pkg::DATA_W-1:0] data_in;

	modport source (output valid, output mode, output data_in, input ready);
	modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface tpf_out_if;
	logic                         valid;
	logic                         ready;
	logic [tpf_pkg::DATA_W-1:0]   data_out;
	logic                         from_urgent;
	logic [tpf_pkg::STATUS_W-1:0] status;
	logic [tpf_pkg::LEVEL_W-1:0]  normal_level;
	logic [tpf_pkg::LEVEL_W-1:0]  urgent_level;

	modport source (output valid, output data_out, output from_urgent, output status,
		output normal_level, output urgent_level, input ready);
	modport sink   (input valid, input data_out, input from_urgent, input status,
		input normal_level, input urgent_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tpf_queue.sv @@
// One circular queue: word memory, read/write pointers and fill count.
`timescale 1ns / 1ps
`default_nettype none

module tpf_queue #(
	parameter int DEPTH = tpf_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire tpf_pkg::queue_cmd_t  cmd,
	input  wire [tpf_pkg::DATA_W-1:0] wr_data,
	output logic [CW-1:0]             count,
	output logic [tpf_pkg::DATA_W-1:0] rd_data
);

	logic [tpf_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]              wr_ptr_q;
	logic [AW-1:0]              rd_ptr_q;
	logic [CW-1:0]              count_q;
	logic [tpf_pkg::DATA_W-1:0] rd_data_q;

	// Write lands at the edge; a pop of that entry comes in the following cycle at the earliest.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
		if (cmd.pop) begin
			rd_data_q <= mem_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end else if (cmd.pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
		end
	end

	assign count   = count_q;
	assign rd_data = rd_data_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop in one cycle");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q != CW'(DEPTH))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> count_q == $past(count_q) - 1'b1)
		else $error("count not decremented by pop");
`endif

endmodule

`default_nettype wire

@@ rtl/core/two_level_priority_fifo_top.sv @@
// Top level of the two-level strict-priority FIFO.
`timescale 1ns / 1ps
`default_nettype none

// Two circular queues of 64-bit words, normal and urgent, DEPTH entries each,
// kept in synchronous memories. Every input transaction either pushes data_in
// into one queue (mode 0 normal, 1 urgent) or pops (mode bit 1 set, so mode 3
// pops too). A pop takes from the urgent queue whenever it holds a word and
// from the normal queue only otherwise. Each input transaction yields exactly
// one result transaction: the popped word (zero unless a pop succeeded), the
// queue it came from, a status (done, push rejected on full queue, pop with
// both queues empty) and both fill levels after the step, masked to 5 bits.
// A rejected push or empty pop changes no state. One input transaction is
// taken per clock while stage 1 can move on. The result passes through
// stage 1 and then the output register before it is offered, because the
// memory read issued at acceptance lands in the queue's read register and is
// captured in the output register as stage 1 moves on. Pointer and count
// updates happen at acceptance, so back-to-back push/pop of the same entry
// needs no forwarding. The output register lets a new transaction enter while
// a result waits; with the sink stalled, at most two transactions are in
// flight. No clearing pass: the block is ready straight out of reset.
module two_level_priority_fifo_top #(
	parameter int DEPTH = tpf_pkg::DEPTH_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	tpf_in_if.sink    in_chan,
	tpf_out_if.source out_chan
);

	localparam int CW = $clog2(DEPTH + 1);

	// Queue state seen at acceptance.
	logic [CW-1:0]              n_count;
	logic [CW-1:0]              u_count;
	logic [tpf_pkg::DATA_W-1:0] n_rd_data;
	logic [tpf_pkg::DATA_W-1:0] u_rd_data;
	tpf_pkg::queue_cmd_t        n_cmd;
	tpf_pkg::queue_cmd_t        u_cmd;

	logic                         accept;
	logic                         is_pop;
	logic                         to_urgent;
	logic                         n_nonempty;
	logic                         u_nonempty;
	logic                         n_full;
	logic                         u_full;
	logic [tpf_pkg::STATUS_W-1:0] status_d;
	logic [CW-1:0]                n_next;
	logic [CW-1:0]                u_next;

	// Stage 1: decision made, memory read in flight.
	logic                         valid_s1;
	logic                         pop_ok_s1;
	logic                         from_urgent_s1;
	logic [tpf_pkg::STATUS_W-1:0] status_s1;
	logic [tpf_pkg::LEVEL_W-1:0]  n_level_s1;
	logic [tpf_pkg::LEVEL_W-1:0]  u_level_s1;
	logic                         advance_s1;

	// Output register.
	logic                         out_valid_q;
	logic [tpf_pkg::DATA_W-1:0]   data_out_q;
	logic                         from_urgent_q;
	logic [tpf_pkg::STATUS_W-1:0] status_q;
	logic [tpf_pkg::LEVEL_W-1:0]  n_level_q;
	logic [tpf_pkg::LEVEL_W-1:0]  u_level_q;

	tpf_queue #(.DEPTH(DEPTH)) u_normal_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (n_cmd),
		.wr_data (in_chan.data_in),
		.count   (n_count),
		.rd_data (n_rd_data)
	);

	tpf_queue #(.DEPTH(DEPTH)) u_urgent_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (u_cmd),
		.wr_data (in_chan.data_in),
		.count   (u_count),
		.rd_data (u_rd_data)
	);

	// Stage 1 moves on when the output register is free or being emptied.
	assign advance_s1    = valid_s1 && (!out_valid_q || out_chan.ready);
	assign in_chan.ready = !valid_s1 || advance_s1;
	assign accept        = in_chan.valid && in_chan.ready;

	assign is_pop     = in_chan.mode[tpf_pkg::MODE_POP_BIT];
	assign to_urgent  = in_chan.mode[tpf_pkg::MODE_URGENT_BIT];
	assign n_nonempty = (n_count != '0);
	assign u_nonempty = (u_count != '0);
	assign n_full     = (n_count == CW'(DEPTH));
	assign u_full     = (u_count == CW'(DEPTH));

	// Strict priority: urgent first, normal only when urgent is empty.
	always_comb begin
		u_cmd.pop  = accept && is_pop && u_nonempty;
		n_cmd.pop  = accept && is_pop && !u_nonempty && n_nonempty;
		u_cmd.push = accept && !is_pop && to_urgent && !u_full;
		n_cmd.push = accept && !is_pop && !to_urgent && !n_full;
	end

	always_comb begin
		if (is_pop) begin
			status_d = (u_nonempty || n_nonempty) ? tpf_pkg::ST_DONE : tpf_pkg::ST_EMPTY;
		end else begin
			status_d = (to_urgent ? u_full : n_full) ? tpf_pkg::ST_FULL : tpf_pkg::ST_DONE;
		end
	end

	// Levels after this step.
	assign n_next = n_count + CW'(n_cmd.push) - CW'(n_cmd.pop);
	assign u_next = u_count + CW'(u_cmd.push) - CW'(u_cmd.pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.ready) begin
			valid_s1 <= in_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1      <= u_cmd.pop || n_cmd.pop;
			from_urgent_s1 <= u_cmd.pop;
			status_s1      <= status_d;
			n_level_s1     <= tpf_pkg::LEVEL_W'(n_next);
			u_level_s1     <= tpf_pkg::LEVEL_W'(u_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Memory read data stays put until the next pop is accepted, which
	// can only happen at or after the edge where stage 1 moves on.
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			if (pop_ok_s1) begin
				data_out_q <= from_urgent_s1 ? u_rd_data : n_rd_data;
			end else begin
				data_out_q <= '0;
			end
			from_urgent_q <= from_urgent_s1;
			status_q      <= status_s1;
			n_level_q     <= n_level_s1;
			u_level_q     <= u_level_s1;
		end
	end

	assign out_chan.valid        = out_valid_q;
	assign out_chan.data_out     = data_out_q;
	assign out_chan.from_urgent  = from_urgent_q;
	assign out_chan.status       = status_q;
	assign out_chan.normal_level = n_level_q;
	assign out_chan.urgent_level = u_level_q;

`ifndef SYNTHESIS
	a_pop_priority: assert property (@(posedge clk) disable iff (!arst_n)
		n_cmd.pop |-> u_count == '0)
		else $error("normal pop while urgent holds data");
	a_urgent_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && from_urgent_s1) |-> (pop_ok_s1 && status_s1 == tpf_pkg::ST_DONE))
		else $error("urgent flag without successful pop");
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_chan.ready) |-> !accept)
		else $error("transaction accepted with both stages blocked");
	a_failed_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_d != tpf_pkg::ST_DONE) |=>
			(n_count == $past(n_count) && u_count == $past(u_count)))
		else $error("rejected transaction changed a count");
`endif

endmodule

`default_nettype wire

@@ bench/two_level_priority_fifo_top_test.sv @@
// Self-checking testbench for the two-level strict-priority FIFO top level.
`timescale 1ns / 1ps

module two_level_priority_fifo_top_test;

	import tpf_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;

	// Mode codes as seen on the input channel; bit 1 set means pop.
	localparam logic [MODE_W-1:0] MODE_PUSH_NORMAL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_URGENT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_POP         = 2'd2;
	localparam logic [MODE_W-1:0] MODE_POP_ALT     = 2'd3;

	// Result pipeline is stage 1 then the output register; DRAIN_CYCLES covers the tail.
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [DATA_W-1:0]   word;
		logic                urgent;
		logic [STATUS_W-1:0] status;
		logic [LEVEL_W-1:0]  normal_level;
		logic [LEVEL_W-1:0]  urgent_level;
	} fifo_result_t;

	logic clk = 1'b0;
	logic arst_n;

	tpf_in_if  in_chan ();
	tpf_out_if out_chan ();

	two_level_priority_fifo_top #(
		.DEPTH(QDEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_chan (in_chan),
		.out_chan(out_chan)
	);

	always #4 clk = ~clk;

	// Shadow copy of both queues, oldest word at the front.
	logic [DATA_W-1:0] normal_words[$];
	logic [DATA_W-1:0] urgent_words[$];

	// Results predicted at input acceptance, oldest first.
	fifo_result_t pending_results[$];

	int  mismatch_count  = 0;
	int  source_idle_pct = 0;
	int  sink_idle_pct   = 0;
	// Forces the result sink to hold ready low; owned by hold_sink only.
	logic sink_hold = 1'b0;

	// Strict-priority step: urgent is always drained first on a pop; a push
	// into a full queue and a pop with both queues empty leave state alone.
	function automatic void apply_priority_step(input logic [MODE_W-1:0] m,
			input logic [DATA_W-1:0] d);
		fifo_result_t r;
		r = '0;
		r.status = ST_DONE;
		if (m[MODE_POP_BIT]) begin
			if (urgent_words.size() != 0) begin
				r.word   = urgent_words.pop_front();
				r.urgent = 1'b1;
			end else if (normal_words.size() != 0) begin
				r.word = normal_words.pop_front();
			end else begin
				r.status = ST_EMPTY;
			end
		end else if (m[MODE_URGENT_BIT]) begin
			if (urgent_words.size() >= QDEPTH)
				r.status = ST_FULL;
			else
				urgent_words.push_back(d);
		end else begin
			if (normal_words.size() >= QDEPTH)
				r.status = ST_FULL;
			else
				normal_words.push_back(d);
		end
		r.normal_level = LEVEL_W'(normal_words.size());
		r.urgent_level = LEVEL_W'(urgent_words.size());
		pending_results.push_back(r);
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return {$urandom, $urandom};
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_val,
			input logic [DATA_W-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_val,
				act_val);
			mismatch_count++;
		end
	endfunction

	// Offers one transaction, with random idle cycles ahead of it, and holds
	// it until the block takes it. Called right after a rising edge.
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] d);
		while ($urandom_range(0, 99) < source_idle_pct) begin
			in_chan.valid <= 1'b0;
			@(posedge clk);
		end
		in_chan.valid   <= 1'b1;
		in_chan.mode    <= m;
		in_chan.data_in <= d;
		@(posedge clk);
		while (!in_chan.ready)
			@(posedge clk);
		apply_priority_step(m, d);
	endtask

	task automatic hold_sink(input int cycles);
		sink_hold <= 1'b1;
		repeat (cycles) @(posedge clk);
		sink_hold <= 1'b0;
	endtask

	// Empty pops of both pop codes, data extremes, and urgent-before-normal order.
	task automatic test_directed_basics();
		send_item(MODE_POP, '1);
		send_item(MODE_POP_ALT, '0);
		send_item(MODE_PUSH_NORMAL, '0);
		send_item(MODE_PUSH_NORMAL, '1);
		send_item(MODE_PUSH_URGENT, 64'h8000_0000_0000_0001);
		send_item(MODE_PUSH_URGENT, 64'h0123_4567_89ab_cdef);
		send_item(MODE_POP, '0);
		send_item(MODE_PUSH_NORMAL, 64'h5555_aaaa_5555_aaaa);
		send_item(MODE_POP_ALT, '1);
		send_item(MODE_POP, '0);
		send_item(MODE_PUSH_URGENT, '1);
		send_item(MODE_POP, '0);
		send_item(MODE_POP_ALT, '0);
		send_item(MODE_POP, '0);
		send_item(MODE_POP_ALT, '0);
	endtask

	// Both queues to full, one rejected push each, then drain past empty.
	task automatic test_full_queues();
		int i;
		for (i = 0; i <= QDEPTH; i++)
			send_item(MODE_PUSH_NORMAL, random_word());
		for (i = 0; i <= QDEPTH; i++)
			send_item(MODE_PUSH_URGENT, random_word());
		// freeing one urgent slot lets the next push in; the normal stays full
		send_item(MODE_POP, '0);
		send_item(MODE_PUSH_URGENT, '1);
		send_item(MODE_PUSH_NORMAL, '1);
		for (i = 0; i <= 2 * QDEPTH; i++)
			send_item((i % 3 == 0) ? MODE_POP_ALT : MODE_POP, random_word());
	endtask

	// Sink stalls for a long stretch while the source keeps offering, so the
	// in-flight slots fill and the input channel must back up.
	task automatic test_sink_stall();
		int saved_idle;
		int i;
		saved_idle      = source_idle_pct;
		source_idle_pct = 0;
		fork
			hold_sink(300);
			begin
				for (i = 0; i < 24; i++)
					send_item((i % 4 == 3) ? MODE_POP : ((i % 2) ? MODE_PUSH_URGENT :
						MODE_PUSH_NORMAL), random_word());
			end
		join
		source_idle_pct = saved_idle;
	endtask

	// Bursts lean toward pushing or popping so the levels sweep between
	// empty and full and both reject cases come up often.
	task automatic test_random_traffic(input int count, input int src_idle, input int snk_idle);
		int sent;
		int burst_len;
		int push_pct;
		int k;
		logic [MODE_W-1:0] m;
		source_idle_pct = src_idle;
		sink_idle_pct   = snk_idle;
		sent = 0;
		while (sent < count) begin
			burst_len = $urandom_range(8, 48);
			case ($urandom_range(0, 2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			for (k = 0; k < burst_len && sent < count; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					m = $urandom_range(0, 1) ? MODE_PUSH_URGENT : MODE_PUSH_NORMAL;
				else
					m = ($urandom_range(0, 3) == 0) ? MODE_POP_ALT : MODE_POP;
				send_item(m, random_word());
				sent++;
			end
		end
	endtask

	// Result sink: random ready, and every result transaction is checked
	// against the oldest prediction.
	initial begin
		fifo_result_t exp_r;
		out_chan.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_chan.valid && out_chan.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual data %h status %0d",
						$realtime, out_chan.data_out, out_chan.status);
					mismatch_count++;
				end else begin
					exp_r = pending_results.pop_front();
					check_field("data_out", exp_r.word, out_chan.data_out);
					check_field("from_urgent", DATA_W'(exp_r.urgent),
						DATA_W'(out_chan.from_urgent));
					check_field("status", DATA_W'(exp_r.status), DATA_W'(out_chan.status));
					check_field("normal_level", DATA_W'(exp_r.normal_level),
						DATA_W'(out_chan.normal_level));
					check_field("urgent_level", DATA_W'(exp_r.urgent_level),
						DATA_W'(out_chan.urgent_level));
				end
			end
			if (!arst_n)
				out_chan.ready <= 1'b0;
			else
				out_chan.ready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Watchdog: far above the slowest legal run of about 2000 transactions.
	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		in_chan.valid   <= 1'b0;
		in_chan.mode    <= MODE_PUSH_NORMAL;
		in_chan.data_in <= '0;
		arst_n          <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		source_idle_pct = 25;
		sink_idle_pct   = 48;
		test_directed_basics();
		test_full_queues();
		test_sink_stall();

		test_random_traffic(640, 25, 48);
		test_random_traffic(640, 48, 25);
		test_random_traffic(640, 0, 0);

		in_chan.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ two_level_priority_fifo_top.f @@
rtl/core/tpf_pkg.sv
rtl/core/tpf_if.sv
rtl/core/tpf_queue.sv
rtl/core/two_level_priority_fifo_top.sv
bench/two_level_priority_fifo_top_test.sv
